### design/iamc_pkg.sv
// Package for the incline actuator mode controller.
// Holds mode, drive and operation codes, register indexes and the divide-by-ten constants.
`timescale 1ns / 1ps
package iamc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_RUNNING = 3'd1,
    MODE_RETRACT = 3'd2,
    MODE_MANUAL  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    DRIVE_OFF = 2'd0,
    DRIVE_FWD = 2'd1,
    DRIVE_REV = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_MANUAL = 2'd2,
    OP_STOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_TARGET_ANGLE   = 3'd0,
    REG_STALL_LIMIT    = 3'd1,
    REG_RETRACT_TICKS  = 3'd2,
    REG_MANUAL_TICKS   = 3'd3,
    REG_HOME_THRESHOLD = 3'd4
  } reg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [14:0] STALL_LIMIT_RST    = 15'd10000;
  localparam logic [15:0] RETRACT_TICKS_RST  = 16'd3000;
  localparam logic [15:0] MANUAL_TICKS_RST   = 16'd200;
  localparam logic [14:0] HOME_THRESHOLD_RST = 15'd50;

  // truncating divide by ten: q = (a * RECIP_10) >> RECIP_SHIFT, exact for a < 2^18
  localparam logic [16:0] RECIP_10    = 17'd104858;
  localparam int unsigned RECIP_SHIFT = 20;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [15:0] measured_angle;
    logic signed [7:0] manual_direction;
  } in_word_t;

  typedef struct packed {
    logic [1:0] drive;
    logic       done_res;
    logic       busy_res;
  } out_word_t;

endpackage

### design/iamc_if.sv
// Valid/ready channel interfaces for the incline actuator mode controller.
// Input word and result word; no package dependency.
`timescale 1ns / 1ps
interface iamc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [15:0] measured_angle;
  logic signed [7:0] manual_direction;

  modport source (output valid, operation, measured_angle, manual_direction, input ready);
  modport sink   (input valid, operation, measured_angle, manual_direction, output ready);
endinterface

interface iamc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] drive;
  logic       done_res;
  logic       busy_res;

  modport source (output valid, drive, done_res, busy_res, input ready);
  modport sink   (input valid, drive, done_res, busy_res, output ready);
endinterface

### design/incline_actuator_mode_controller.sv
// Incline actuator mode controller, top level.
// Uses iamc_pkg, iamc_if channels and iamc_core.
//
// Usage:
//   in_ch  carries one word per command: tick, start run, manual command, stop,
//          with the measured angle and manual direction.
//   out_ch returns exactly one word per input word: drive held, done, busy.
//   cfg_we/cfg_index/cfg_data write the five setup registers (target angle,
//   stall limit, retract ticks, manual ticks, home threshold); write only while
//   no word is in flight.
// Timing:
//   A word is registered at acceptance, stepped through the mode logic once
//   the output register is free or being drained, and lands in the output
//   register, which drives out_ch.valid; a stall can hold it in between.
//   One word per cycle is sustained while out_ch.ready stays high; the bias
//   divide is a single 17x17 reciprocal multiply within the step cycle.
// Reset (rst_n low, synchronous): mode idle, drive off, counters and history
//   cleared, registers to their defaults, both pipeline registers empty.
// Backpressure: while out_ch.ready is low a held result stays put, the input
//   register holds one more word, and in_ch.ready drops only when both are full.
`timescale 1ns / 1ps
module incline_actuator_mode_controller
  import iamc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  iamc_in_if.sink               in_ch,
  iamc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      in_vld_r;
  in_word_t  in_word_r;
  logic      out_vld_r;
  out_word_t out_word_r;
  out_word_t result;
  logic      advance;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_word_r.operation        <= in_ch.operation;
      in_word_r.measured_angle   <= in_ch.measured_angle;
      in_word_r.manual_direction <= in_ch.manual_direction;
    end
  end

  iamc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_en   (advance),
    .word      (in_word_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_word_r <= result;
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.drive    = out_word_r.drive;
  assign out_ch.done_res = out_word_r.done_res;
  assign out_ch.busy_res = out_word_r.busy_res;

  a_idle_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_word_r.busy_res |-> out_word_r.drive == DRIVE_OFF)
    else $error("drive not off while idle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_word_r.done_res |-> !out_word_r.busy_res)
    else $error("done reported while still busy");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("stepped word lost before output register");

  a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r)
    else $error("input word dropped while stalled");

endmodule

### design/iamc_bias.sv
// Bias unit: (target - measured) / 10 truncated toward zero, in tenths of a degree.
// Uses the reciprocal constants from iamc_pkg.
`timescale 1ns / 1ps
module iamc_bias
  import iamc_pkg::*;
(
  input  logic signed [15:0] target_angle,
  input  logic signed [15:0] measured_angle,
  output logic signed [15:0] bias
);

  logic signed [16:0] diff;
  logic               neg;
  logic [16:0]        mag;
  logic [33:0]        prod;
  logic [33:0]        quot_full;
  logic [13:0]        quot;

  always_comb begin
    diff      = {target_angle[15], target_angle} - {measured_angle[15], measured_angle};
    neg       = diff[16];
    mag       = neg ? 17'(-diff) : 17'(diff);
    prod      = {17'd0, mag} * {17'd0, RECIP_10};
    quot_full = prod >> RECIP_SHIFT;
    quot      = quot_full[13:0];
    bias      = neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  end

endmodule

### design/iamc_core.sv
// Mode state, configuration registers and per-word step logic.
// Depends on iamc_pkg and iamc_bias.
`timescale 1ns / 1ps
module iamc_core
  import iamc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step_en,
  input  in_word_t              word,
  output out_word_t             result
);

  logic signed [15:0] target_angle_r;
  logic [14:0]        stall_limit_r;
  logic [15:0]        retract_ticks_r;
  logic [15:0]        manual_ticks_r;
  logic [14:0]        home_threshold_r;

  mode_t              mode_r, mode_nxt;
  logic [15:0]        tick_r, tick_nxt;
  logic signed [15:0] prev_bias_r, prev_bias_nxt;
  logic [15:0]        stall_r, stall_nxt;
  logic signed [7:0]  held_dir_r, held_dir_nxt;
  drive_t             drive_r, drive_nxt;
  logic               finish;
  logic signed [15:0] bias;
  logic [15:0]        tick_inc;

  iamc_bias u_bias (
    .target_angle   (target_angle_r),
    .measured_angle (word.measured_angle),
    .bias           (bias)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_angle_r   <= '0;
      stall_limit_r    <= STALL_LIMIT_RST;
      retract_ticks_r  <= RETRACT_TICKS_RST;
      manual_ticks_r   <= MANUAL_TICKS_RST;
      home_threshold_r <= HOME_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TARGET_ANGLE:   target_angle_r   <= $signed(cfg_data);
        REG_STALL_LIMIT:    stall_limit_r    <= cfg_data[14:0];
        REG_RETRACT_TICKS:  retract_ticks_r  <= cfg_data;
        REG_MANUAL_TICKS:   manual_ticks_r   <= cfg_data;
        REG_HOME_THRESHOLD: home_threshold_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign tick_inc = (tick_r == 16'hFFFF) ? tick_r : tick_r + 16'd1;

  always_comb begin
    mode_nxt      = mode_r;
    tick_nxt      = tick_r;
    prev_bias_nxt = prev_bias_r;
    stall_nxt     = stall_r;
    held_dir_nxt  = held_dir_r;
    drive_nxt     = drive_r;
    finish        = 1'b0;
    case (op_t'(word.operation))
      OP_START: begin
        mode_nxt = MODE_RUNNING;
        tick_nxt = '0;
      end
      OP_MANUAL: begin
        if (mode_r == MODE_IDLE) mode_nxt = MODE_MANUAL;
        tick_nxt     = '0;
        held_dir_nxt = word.manual_direction;
      end
      OP_STOP: begin
        mode_nxt  = MODE_IDLE;
        drive_nxt = DRIVE_OFF;
      end
      default: begin
        if (mode_r == MODE_RUNNING) begin
          if (bias == prev_bias_r)
            stall_nxt = (stall_r == 16'hFFFF) ? stall_r : stall_r + 16'd1;
          else
            stall_nxt = '0;
          if (stall_nxt > {1'b0, stall_limit_r}) finish = 1'b1;
          prev_bias_nxt = bias;
          if (bias > 16'sd0) begin
            drive_nxt = DRIVE_FWD;
          end else if (bias < 16'sd0) begin
            drive_nxt = DRIVE_REV;
          end else begin
            drive_nxt = DRIVE_OFF;
            if (target_angle_r < $signed({1'b0, home_threshold_r}))
              mode_nxt = MODE_RETRACT;
            else
              finish = 1'b1;
          end
        end
        if (mode_nxt == MODE_RETRACT) begin
          tick_nxt  = tick_inc;
          drive_nxt = DRIVE_REV;
          if (tick_inc > retract_ticks_r) finish = 1'b1;
        end
        if (mode_nxt == MODE_MANUAL) begin
          if (held_dir_r == 8'sd1)       drive_nxt = DRIVE_FWD;
          else if (held_dir_r == -8'sd1) drive_nxt = DRIVE_REV;
          else                           drive_nxt = DRIVE_OFF;
          tick_nxt = tick_inc;
          if (tick_inc > manual_ticks_r) finish = 1'b1;
        end
        if (finish) begin
          mode_nxt  = MODE_IDLE;
          drive_nxt = DRIVE_OFF;
        end
      end
    endcase
    result.drive    = drive_nxt;
    result.done_res = finish;
    result.busy_res = (mode_nxt != MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      tick_r      <= '0;
      prev_bias_r <= '0;
      stall_r     <= '0;
      held_dir_r  <= '0;
      drive_r     <= DRIVE_OFF;
    end else if (step_en) begin
      mode_r      <= mode_nxt;
      tick_r      <= tick_nxt;
      prev_bias_r <= prev_bias_nxt;
      stall_r     <= stall_nxt;
      held_dir_r  <= held_dir_nxt;
      drive_r     <= drive_nxt;
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the incline actuator mode controller.
// Drives command words on in_ch, checks every status word on out_ch against
// an in-bench mode predictor. Depends on iamc_pkg, iamc_if and the top level.
`timescale 1ns / 1ps
module tb_top;
  import iamc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  iamc_in_if  in_ch();
  iamc_out_if out_ch();

  incline_actuator_mode_controller i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor setup registers and state
  logic signed [15:0] target_cfg      = '0;
  logic [14:0]        stall_lim_cfg   = STALL_LIMIT_RST;
  logic [15:0]        retract_lim_cfg = RETRACT_TICKS_RST;
  logic [15:0]        manual_lim_cfg  = MANUAL_TICKS_RST;
  logic [14:0]        home_cfg        = HOME_THRESHOLD_RST;

  mode_t              m_mode      = MODE_IDLE;
  logic [15:0]        m_ticks     = '0;
  logic signed [15:0] m_prev_bias = '0;
  logic [15:0]        m_stall     = '0;
  logic signed [7:0]  m_dir       = '0;
  drive_t             m_drive     = DRIVE_OFF;

  in_word_t  cmd_words[$];
  out_word_t status_due[$];
  in_word_t  cur_word;

  int  words_pushed = 0;
  int  results_seen = 0;
  int  ends_seen    = 0;
  int  mismatches   = 0;
  int  src_gap      = 0;
  int  sink_gap     = 0;
  bit  idle_on      = 1'b1;
  bit  sink_hold    = 1'b0;

  function automatic logic [15:0] count_sat(logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic out_word_t next_status(in_word_t w);
    int        bias;
    logic      finish;
    out_word_t r;
    finish = 1'b0;
    case (op_t'(w.operation))
      OP_START: begin
        m_mode  = MODE_RUNNING;
        m_ticks = '0;
      end
      OP_MANUAL: begin
        if (m_mode == MODE_IDLE) m_mode = MODE_MANUAL;
        m_ticks = '0;
        m_dir   = w.manual_direction;
      end
      OP_STOP: begin
        m_mode  = MODE_IDLE;
        m_drive = DRIVE_OFF;
      end
      default: begin
        if (m_mode == MODE_RUNNING) begin
          bias = (int'(target_cfg) - int'($signed(w.measured_angle))) / 10;
          if (bias == int'(m_prev_bias)) m_stall = count_sat(m_stall);
          else m_stall = '0;
          if (m_stall > {1'b0, stall_lim_cfg}) finish = 1'b1;
          m_prev_bias = 16'(bias);
          if (bias > 0) begin
            m_drive = DRIVE_FWD;
          end else if (bias < 0) begin
            m_drive = DRIVE_REV;
          end else begin
            m_drive = DRIVE_OFF;
            if (int'(target_cfg) < int'(home_cfg)) m_mode = MODE_RETRACT;
            else finish = 1'b1;
          end
        end
        if (m_mode == MODE_RETRACT) begin
          m_ticks = count_sat(m_ticks);
          m_drive = DRIVE_REV;
          if (m_ticks > retract_lim_cfg) finish = 1'b1;
        end
        if (m_mode == MODE_MANUAL) begin
          if (int'(m_dir) == 1) m_drive = DRIVE_FWD;
          else if (int'(m_dir) == -1) m_drive = DRIVE_REV;
          else m_drive = DRIVE_OFF;
          m_ticks = count_sat(m_ticks);
          if (m_ticks > manual_lim_cfg) finish = 1'b1;
        end
        if (finish) begin
          m_mode  = MODE_IDLE;
          m_drive = DRIVE_OFF;
        end
      end
    endcase
    r.drive    = m_drive;
    r.done_res = finish;
    r.busy_res = (m_mode != MODE_IDLE);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // command word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) status_due.push_back(next_status(cur_word));
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered word
      end else if (src_gap != 0) begin
        src_gap     <= src_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        src_gap     <= $urandom_range(0, 14);
        in_ch.valid <= 1'b0;
      end else if (cmd_words.size() != 0) begin
        cur_word               = cmd_words.pop_front();
        in_ch.valid            <= 1'b1;
        in_ch.operation        <= cur_word.operation;
        in_ch.measured_angle   <= cur_word.measured_angle;
        in_ch.manual_direction <= cur_word.manual_direction;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // status word monitor
  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected status word: drive %0d done %0b busy %0b",
                     out_ch.drive, out_ch.done_res, out_ch.busy_res);
        end else begin
          want = status_due.pop_front();
          if (out_ch.drive !== want.drive || out_ch.done_res !== want.done_res ||
              out_ch.busy_res !== want.busy_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Status word %0d: drive %0d/%0d done %0b/%0b busy %0b/%0b (exp/got)",
                       results_seen, want.drive, out_ch.drive, want.done_res,
                       out_ch.done_res, want.busy_res, out_ch.busy_res);
          end
          if (want.done_res) ends_seen++;
        end
      end
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap     <= sink_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap     <= $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic int rand_ang();
    return int'($urandom_range(0, 36000)) - 18000;
  endfunction

  function automatic int rand_dir();
    return int'($urandom_range(0, 255)) - 128;
  endfunction

  function automatic int pick_dir();
    case ($urandom_range(0, 4))
      0: return 1;
      1: return -1;
      2: return 0;
      default: return rand_dir();
    endcase
  endfunction

  function automatic int clamp_ang(int a);
    if (a > 18000) return 18000;
    if (a < -18000) return -18000;
    return a;
  endfunction

  task automatic queue_word(op_t op, int ang, int dir);
    in_word_t w;
    w.operation        = op;
    w.measured_angle   = 16'(ang);
    w.manual_direction = 8'(dir);
    cmd_words.push_back(w);
    words_pushed++;
  endtask

  task automatic set_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TARGET_ANGLE:  target_cfg      = val;
      REG_STALL_LIMIT:   stall_lim_cfg   = val[14:0];
      REG_RETRACT_TICKS: retract_lim_cfg = val;
      REG_MANUAL_TICKS:  manual_lim_cfg  = val;
      default:           home_cfg        = val[14:0];
    endcase
  endtask

  task automatic apply_setup(int target, int stall, int retract, int manual, int home);
    set_reg(REG_TARGET_ANGLE, 16'(target));
    set_reg(REG_STALL_LIMIT, 16'(stall));
    set_reg(REG_RETRACT_TICKS, 16'(retract));
    set_reg(REG_MANUAL_TICKS, 16'(manual));
    set_reg(REG_HOME_THRESHOLD, 16'(home));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (cmd_words.size() != 0 || in_ch.valid || status_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // start, converging ticks with repeats, then arrival and a few trailing ticks
  task automatic push_run();
    int ang;
    ang = rand_ang();
    queue_word(OP_START, rand_ang(), rand_dir());
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 9) < 3) begin
        // repeat the angle: stall
      end else if ($urandom_range(0, 9) < 8) begin
        ang = clamp_ang(int'(target_cfg) + (ang - int'(target_cfg)) / 3 +
                        int'($urandom_range(0, 20)) - 10);
      end else begin
        ang = rand_ang();
      end
      queue_word(OP_TICK, ang, rand_dir());
    end
    queue_word(OP_TICK, clamp_ang(int'(target_cfg) + int'($urandom_range(0, 18)) - 9),
               rand_dir());
    repeat ($urandom_range(0, 7)) queue_word(OP_TICK, rand_ang(), rand_dir());
    if ($urandom_range(0, 7) == 0) queue_word(OP_STOP, rand_ang(), rand_dir());
  endtask

  task automatic push_manual();
    queue_word(OP_MANUAL, rand_ang(), pick_dir());
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 9) == 0) queue_word(OP_MANUAL, rand_ang(), pick_dir());
      else queue_word(OP_TICK, rand_ang(), rand_dir());
    end
  endtask

  initial begin
    int n0;
    int r;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    in_ch.valid            = 1'b0;
    in_ch.operation        = OP_TICK;
    in_ch.measured_angle   = '0;
    in_ch.manual_direction = '0;
    out_ch.ready           = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // target at top, tightest stall limit, home at zero
    apply_setup(18000, 0, 0, 1, 0);
    queue_word(OP_TICK, -18000, -128);
    queue_word(OP_STOP, 18000, 127);
    queue_word(OP_MANUAL, 0, 1);
    queue_word(OP_TICK, 0, 0);
    queue_word(OP_MANUAL, 0, -1);
    queue_word(OP_TICK, 0, 0);
    queue_word(OP_TICK, 0, 0);
    queue_word(OP_MANUAL, 0, 127);
    queue_word(OP_TICK, 0, 0);
    queue_word(OP_STOP, 0, 0);
    queue_word(OP_START, 0, 0);
    queue_word(OP_TICK, -18000, 0);
    queue_word(OP_TICK, -18000, 0);
    queue_word(OP_START, 0, 0);
    queue_word(OP_TICK, 17995, 0);
    wait_idle();

    // target at bottom below home: retract on arrival
    apply_setup(-18000, 32767, 2, 0, 18000);
    queue_word(OP_START, 0, 0);
    queue_word(OP_TICK, -17991, 0);
    queue_word(OP_TICK, 0, 0);
    queue_word(OP_TICK, 0, 0);
    queue_word(OP_START, 0, 0);
    queue_word(OP_TICK, 18000, 0);
    queue_word(OP_MANUAL, 0, -1);
    queue_word(OP_STOP, 0, 0);
    queue_word(OP_MANUAL, 0, 0);
    queue_word(OP_TICK, 0, 0);

    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      r = $urandom_range(0, 5);
      apply_setup((r == 0) ? -18000 : (r == 1) ? 18000 : (r == 2) ? 0 : rand_ang(),
                  ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(0, 4),
                  ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 5),
                  ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 5),
                  ($urandom_range(0, 3) == 0) ? 18000 : $urandom_range(0, 18000));
      idle_on = (ph < 10) && ($urandom_range(0, 3) != 0);
      n0 = words_pushed;
      while (words_pushed - n0 < 110) begin
        r = $urandom_range(0, 9);
        if (r < 6) push_run();
        else if (r < 8) push_manual();
        else queue_word(op_t'($urandom_range(0, 3)), rand_ang(), rand_dir());
      end
      if (ph == 3) begin
        // stall the result side long enough to back up the input
        sink_hold = 1'b1;
        repeat (80) @(negedge clk);
        sink_hold = 1'b0;
      end
    end

    // tick limits at the top: manual motion runs on without ending
    wait_idle();
    apply_setup(-18000, 4, 65535, 65535, 18000);
    queue_word(OP_MANUAL, 0, 1);
    repeat (20) queue_word(OP_TICK, rand_ang(), rand_dir());
    queue_word(OP_STOP, 0, 0);
    queue_word(OP_START, 0, 0);
    repeat (6) queue_word(OP_TICK, -18000, rand_dir());
    queue_word(OP_STOP, 0, 0);
    wait_idle();

    $display("Checked %0d status words from %0d command words, %0d motion endings seen,",
             results_seen, words_pushed, ends_seen);
    $display("over directed setups, 12 random setups and a long-limit manual run.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d status word mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d status words outstanding", status_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
